// ===== sv/hptu_pkg.sv =====
// Package for the homogeneous point transform unit: types, constants and helpers.
package hptu_pkg;

  localparam int NUM_COMP  = 4;
  localparam int COEF_W    = 16;
  localparam int VAL_W     = 32;
  localparam int PROD_W    = COEF_W + VAL_W;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int SUM_W     = PROD_W + 2;
  localparam int FRAC_SH   = 8;
  localparam int RES_W     = SUM_W - FRAC_SH;
  localparam int Q_BITS    = 32;
  localparam int NUM_W     = RES_W + 16 + 2;
  localparam int DEN_W     = RES_W + 1;
  localparam int CMP_W     = DEN_W + Q_BITS + 1;
  localparam int LANE_LAT  = 3;
  localparam int DIV_LAT   = Q_BITS + 1;
  localparam int PIPE_LAT  = LANE_LAT + DIV_LAT + 1;
  localparam int CFG_IDX_W = 8;

  localparam logic signed [VAL_W-1:0] ONE_Q16 = 32'sd65536;
  localparam logic signed [VAL_W-1:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] Q_MIN   = 32'sh8000_0000;

  localparam logic [63:0] MATRIX_RESET [NUM_COMP] = '{
    64'h0000_0000_0000_0100,
    64'h0000_0000_0100_0000,
    64'h0000_0100_0000_0000,
    64'h0100_0000_0000_0000
  };

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [RES_W-1:0]  res_t;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
    logic               point_form;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               divide_fault;
  } out_t;

  typedef struct packed {
    logic point;
    logic fault;
    logic neg_x;
    logic neg_y;
    logic neg_z;
    val_t sat_x;
    val_t sat_y;
    val_t sat_z;
    val_t sat_w;
  } side_t;

  function automatic val_t sat32(input res_t v);
    if (v > res_t'(Q_MAX)) begin
      return Q_MAX;
    end else if (v < res_t'(Q_MIN)) begin
      return Q_MIN;
    end
    return val_t'(v);
  endfunction

endpackage

// ===== sv/hptu_lane.sv =====
// One row lane: four coefficient products, a two-level sum and round to a Q26.16 result.
module hptu_lane (
  input  logic                  clk,
  input  logic                  en,
  input  hptu_pkg::coef_t       coef [hptu_pkg::NUM_COMP],
  input  hptu_pkg::val_t        vec  [hptu_pkg::NUM_COMP],
  output hptu_pkg::res_t        res
);

  logic signed [hptu_pkg::PROD_W-1:0] prod [hptu_pkg::NUM_COMP];
  logic signed [hptu_pkg::PAIR_W-1:0] pair_lo;
  logic signed [hptu_pkg::PAIR_W-1:0] pair_hi;
  logic signed [hptu_pkg::SUM_W-1:0]  total;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < hptu_pkg::NUM_COMP; c++) begin
        prod[c] <= hptu_pkg::PROD_W'(coef[c]) * hptu_pkg::PROD_W'(vec[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pair_lo <= hptu_pkg::PAIR_W'(prod[0]) + hptu_pkg::PAIR_W'(prod[1]);
      pair_hi <= hptu_pkg::PAIR_W'(prod[2]) + hptu_pkg::PAIR_W'(prod[3]);
    end
  end

  // Round half up: add half an LSB, then an arithmetic shift floors.
  assign total = hptu_pkg::SUM_W'(pair_lo) + hptu_pkg::SUM_W'(pair_hi)
               + hptu_pkg::SUM_W'(128);

  always_ff @(posedge clk) begin
    if (en) begin
      res <= hptu_pkg::res_t'(total >>> hptu_pkg::FRAC_SH);
    end
  end

endmodule

// ===== sv/hptu_div.sv =====
// Pipelined restoring divider: (n * 65536) / d, rounded to nearest, saturated.
module hptu_div (
  input  logic           clk,
  input  logic           en,
  input  hptu_pkg::res_t n,
  input  hptu_pkg::res_t d,
  output hptu_pkg::val_t q
);

  localparam int QB = hptu_pkg::Q_BITS;

  logic [hptu_pkg::NUM_W-1:0] rem  [QB+1];
  logic [hptu_pkg::DEN_W-1:0] den  [QB+1];
  logic [QB-1:0]              quo  [QB+1];
  logic                       neg  [QB+1];
  logic                       big  [QB+1];

  logic [hptu_pkg::RES_W-1:0] an;
  logic [hptu_pkg::RES_W-1:0] ad;
  logic [hptu_pkg::NUM_W-1:0] num0;
  logic [hptu_pkg::DEN_W-1:0] den0;
  logic                       lim;

  assign an   = n[hptu_pkg::RES_W-1] ? hptu_pkg::RES_W'(-n) : hptu_pkg::RES_W'(n);
  assign ad   = d[hptu_pkg::RES_W-1] ? hptu_pkg::RES_W'(-d) : hptu_pkg::RES_W'(d);
  assign num0 = {an, 17'b0} + hptu_pkg::NUM_W'(ad);
  assign den0 = {ad, 1'b0};

  // Set-up stage: operands made positive, quotient overflow caught up front.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num0;
      den[0] <= den0;
      quo[0] <= '0;
      neg[0] <= n[hptu_pkg::RES_W-1] ^ d[hptu_pkg::RES_W-1];
      big[0] <= hptu_pkg::CMP_W'(num0) >= (hptu_pkg::CMP_W'(den0) << QB);
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    localparam int BIT = QB - k;
    logic [hptu_pkg::CMP_W-1:0] trial;
    logic                       take;

    assign trial = hptu_pkg::CMP_W'(den[k-1]) << BIT;
    assign take  = hptu_pkg::CMP_W'(rem[k-1]) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? hptu_pkg::NUM_W'(hptu_pkg::CMP_W'(rem[k-1]) - trial) : rem[k-1];
        den[k] <= den[k-1];
        quo[k] <= quo[k-1] | (QB'(take) << BIT);
        neg[k] <= neg[k-1];
        big[k] <= big[k-1];
      end
    end
  end

  assign lim = big[QB] | quo[QB][QB-1];

  always_comb begin
    if (neg[QB]) begin
      q = lim ? hptu_pkg::Q_MIN : hptu_pkg::val_t'(-quo[QB]);
    end else begin
      q = lim ? hptu_pkg::Q_MAX : hptu_pkg::val_t'(quo[QB]);
    end
  end

endmodule

// ===== sv/homogeneous_point_transform_unit.sv =====
// Top level of the homogeneous point transform unit: 4x4 matrix transform with divide.
//
//   Channel  Signals                                Direction  Payload
//   input    in_valid, in_stall, in_data            in         hptu_pkg::in_t
//   output   out_valid, out_stall, out_data         out        hptu_pkg::out_t
//   config   cfg_valid, cfg_ready, cfg_index/data   in         64-bit matrix column
//
// One transaction is accepted per clock while in_stall is low; each result is
// offered once it has passed 37 registers, the first loaded at its acceptance
// edge: three lane stages, divider set-up plus one quotient bit per stage for 32
// stages, and the output register. Most of those registers lie in the divider.
// Reset is synchronous and clears the valid bits and the matrix to identity.
// A stalled result freezes the whole pipeline, so in_stall follows it.
module homogeneous_point_transform_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  hptu_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output hptu_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hptu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                      cfg_data
);

  localparam int NC = hptu_pkg::NUM_COMP;

  logic [63:0]     matrix [NC];
  logic            en;
  logic            vld    [hptu_pkg::PIPE_LAT];
  logic            pt     [hptu_pkg::LANE_LAT];
  hptu_pkg::side_t side   [hptu_pkg::DIV_LAT];
  hptu_pkg::side_t side_next;
  hptu_pkg::val_t  vec    [NC];
  hptu_pkg::res_t  res    [NC];
  hptu_pkg::val_t  quo    [3];
  hptu_pkg::res_t  den;
  hptu_pkg::out_t  result_next;

  // The matrix is to be written only while the block is idle, so it is always ready; the block does not enforce this.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NC; c++) begin
        matrix[c] <= hptu_pkg::MATRIX_RESET[c];
      end
    end else if (cfg_valid && cfg_index < hptu_pkg::CFG_IDX_W'(NC)) begin
      matrix[cfg_index[1:0]] <= cfg_data;
    end
  end

  // The whole pipeline moves unless a finished result is being held back.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < hptu_pkg::PIPE_LAT; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < hptu_pkg::PIPE_LAT; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  assign out_valid = vld[hptu_pkg::PIPE_LAT-1];

  // In point form the fourth component is replaced by one.
  assign vec[0] = in_data.in_x;
  assign vec[1] = in_data.in_y;
  assign vec[2] = in_data.in_z;
  assign vec[3] = in_data.point_form ? hptu_pkg::ONE_Q16 : in_data.in_w;

  always_ff @(posedge clk) begin
    if (en) begin
      pt[0] <= in_data.point_form;
      for (int k = 1; k < hptu_pkg::LANE_LAT; k++) begin
        pt[k] <= pt[k-1];
      end
    end
  end

  // One lane per matrix row; each lane sees row r of every column.
  for (genvar r = 0; r < NC; r++) begin : g_lane
    hptu_pkg::coef_t row_coef [NC];
    for (genvar c = 0; c < NC; c++) begin : g_col
      assign row_coef[c] = hptu_pkg::coef_t'(matrix[c][16*r +: 16]);
    end
    hptu_lane u_lane (
      .clk  (clk),
      .en   (en),
      .coef (row_coef),
      .vec  (vec),
      .res  (res[r])
    );
  end

  // Details that the final merge needs travel beside the dividers.
  always_comb begin
    side_next.point = pt[hptu_pkg::LANE_LAT-1];
    side_next.fault = pt[hptu_pkg::LANE_LAT-1] && (res[3] == '0);
    side_next.neg_x = res[0][hptu_pkg::RES_W-1];
    side_next.neg_y = res[1][hptu_pkg::RES_W-1];
    side_next.neg_z = res[2][hptu_pkg::RES_W-1];
    side_next.sat_x = hptu_pkg::sat32(res[0]);
    side_next.sat_y = hptu_pkg::sat32(res[1]);
    side_next.sat_z = hptu_pkg::sat32(res[2]);
    side_next.sat_w = hptu_pkg::sat32(res[3]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_next;
      for (int k = 1; k < hptu_pkg::DIV_LAT; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  // A zero w is swapped for one so the dividers never see a zero divisor;
  // their result is discarded in that case anyway.
  assign den = (res[3] == '0) ? hptu_pkg::res_t'(1) : res[3];

  for (genvar r = 0; r < 3; r++) begin : g_div
    hptu_div u_div (
      .clk (clk),
      .en  (en),
      .n   (res[r]),
      .d   (den),
      .q   (quo[r])
    );
  end

  // Merge stage: pick vector, divided or faulted results per item.
  always_comb begin
    hptu_pkg::side_t s;
    s = side[hptu_pkg::DIV_LAT-1];
    result_next.divide_fault = s.fault;
    if (!s.point) begin
      result_next.out_x = s.sat_x;
      result_next.out_y = s.sat_y;
      result_next.out_z = s.sat_z;
      result_next.out_w = s.sat_w;
    end else if (s.fault) begin
      result_next.out_x = s.neg_x ? hptu_pkg::Q_MIN : hptu_pkg::Q_MAX;
      result_next.out_y = s.neg_y ? hptu_pkg::Q_MIN : hptu_pkg::Q_MAX;
      result_next.out_z = s.neg_z ? hptu_pkg::Q_MIN : hptu_pkg::Q_MAX;
      result_next.out_w = '0;
    end else begin
      result_next.out_x = quo[0];
      result_next.out_y = quo[1];
      result_next.out_z = quo[2];
      result_next.out_w = s.sat_w;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= result_next;
    end
  end

  // A faulted result always carries a zero w.
  a_fault_w_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.divide_fault |-> out_data.out_w == '0)
    else $error("faulted result with non-zero w");

  // A faulted result always has x saturated to one end of the range.
  a_fault_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.divide_fault |->
      (out_data.out_x == hptu_pkg::Q_MAX || out_data.out_x == hptu_pkg::Q_MIN))
    else $error("faulted result without saturated x");

  // A new result only appears if the stage before it held an item.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vld[hptu_pkg::PIPE_LAT-2]))
    else $error("result appeared without a preceding item");

endmodule
